// ===== hw/rtl/sbtg_pkg.sv =====
`timescale 1ns / 1ps

package sbtg_pkg;

  // defaults for the top level parameters
  localparam int DEF_PHASE_BITS     = 32;
  localparam int DEF_SINE_ADDR_BITS = 10;
  localparam int DEF_AUDIO_RATE     = 48000;
  localparam int DEF_AMPLITUDE      = 10000;

  // fixed widths of the item fields
  localparam int FREQ_W   = 15;
  localparam int DUR_W    = 16;
  localparam int SAMPLE_W = 15;

  // quarter-wave table entry, holds 0..amplitude
  localparam int TBL_W = 15;

  // sample counter
  localparam int COUNT_BITS = 22;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  // wide enough for duration * rate / 1000 at the highest rate
  localparam int CNT_W = 25;

  localparam int MS_PER_S = 1000;

  // output saturation limits
  localparam int SAMPLE_POS_MAX = 16383;
  localparam int SAMPLE_NEG_MAG = 16384;

  // pi/2 in q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [FREQ_W-1:0] frequency_hz;
    logic [DUR_W-1:0]  length_ms;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } tone_t;

  // quotient by shift and subtract, only used while building the table
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // one quarter-wave table entry, taylor series in q30, evaluated at elaboration
  function automatic logic [TBL_W-1:0] quarter_sine(int unsigned k, int unsigned addr_bits,
                                                    int unsigned amp);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned div;
    longint          sum;
    longint          v;
    x    = (HALF_PI_Q30 * longint'(k)) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n < 40; n++) begin
      div  = longint'(2 * n) * longint'(2 * n + 1);
      term = udiv64(term * x2, div);
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = longint'((longint'(unsigned'(sum)) * longint'(amp)) >> 30);
    if (v > longint'(amp)) begin
      v = longint'(amp);
    end
    return TBL_W'(v);
  endfunction

endpackage

// ===== hw/rtl/sine_beep_tone_generator.sv =====
`timescale 1ns / 1ps

// channel  role    signals                        payload
// req      in      req_valid / req_ready / req    cmd, frequency_hz, length_ms
// tone     out     tone_valid / tone_ready / tone sample, last
//
// tick items are taken one per cycle while req_ready is high; a sample goes out
// through the table read register, then the output register
// for a start item the step and count go through a three-stage
// multiply-by-reciprocal pipeline, and req_ready stays low until it is done
// reset (rst, synchronous) leaves the block idle with phase and step at zero
// a stalled tone side holds the output register; req_ready drops when the
// table read register cannot move on, and while a start is in its pipeline

module sine_beep_tone_generator
  import sbtg_pkg::*;
#(
  parameter int PHASE_BITS     = DEF_PHASE_BITS,
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
  parameter int AUDIO_RATE     = DEF_AUDIO_RATE,
  parameter int AMPLITUDE      = DEF_AMPLITUDE
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  req_t  req,
  output logic  tone_valid,
  input  logic  tone_ready,
  output tone_t tone
);

  // ---------------------------------------------------------------------------
  // elaboration-time constants
  // ---------------------------------------------------------------------------

  localparam int QSIZE  = 1 << SINE_ADDR_BITS;
  localparam int ADDR_W = SINE_ADDR_BITS + 1;

  // frequency saturation point: half the audio rate, capped at the 15-bit field maximum
  localparam int FMAX = AUDIO_RATE / 2;
  localparam int FSAT = (FMAX > 32767) ? 32767 : FMAX;

  // step = f * (2^P div R) + round((f * (2^P mod R)) / R)
  localparam logic [127:0] PH_ONE = 128'd1 << PHASE_BITS;
  localparam logic [127:0] STEP_Q = PH_ONE / AUDIO_RATE;
  localparam logic [127:0] STEP_R = PH_ONE % AUDIO_RATE;
  localparam logic [127:0] RND    = 128'(AUDIO_RATE / 2);
  localparam logic [127:0] LO_MAX = 128'(FSAT) * STEP_R + RND;
  localparam int           LO_W   = $clog2(LO_MAX + 128'd1);
  localparam int           SR_L   = $clog2(AUDIO_RATE);
  localparam int           LO_S   = LO_W + SR_L;
  // exact reciprocal for every dividend below 2^LO_W
  localparam logic [127:0] LO_M   = ((128'd1 << LO_S) + 128'(AUDIO_RATE) - 128'd1)
                                    / AUDIO_RATE;
  localparam int           LO_MW  = $clog2(LO_M + 128'd1);
  localparam int           LO_PW  = LO_W + LO_MW;
  localparam int           QW     = $clog2(FSAT + 1);

  // count = d * (R div 1000) + (d * (R mod 1000)) div 1000
  localparam int           CNT_D  = AUDIO_RATE / MS_PER_S;
  localparam int           CNT_R  = AUDIO_RATE % MS_PER_S;
  localparam int           CM_MAX = 65535 * CNT_R;
  localparam int           CM_W   = (CM_MAX == 0) ? 1 : $clog2(CM_MAX + 1);
  localparam int           MS_L   = $clog2(MS_PER_S);
  localparam int           CM_S   = CM_W + MS_L;
  localparam logic [127:0] CM_M   = ((128'd1 << CM_S) + 128'(MS_PER_S) - 128'd1)
                                    / MS_PER_S;
  localparam int           CM_MW  = $clog2(CM_M + 128'd1);
  localparam int           CM_PW  = CM_W + CM_MW;

  // ---------------------------------------------------------------------------
  // quarter-wave table, constant contents
  // ---------------------------------------------------------------------------

  logic [TBL_W-1:0] sine_rom [QSIZE+1];

  for (genvar k = 0; k < QSIZE; k++) begin : g_rom
    assign sine_rom[k] = quarter_sine(k, SINE_ADDR_BITS, AMPLITUDE);
  end
  assign sine_rom[QSIZE] = TBL_W'(AMPLITUDE);

  // ---------------------------------------------------------------------------
  // handshake and architectural state
  // ---------------------------------------------------------------------------

  logic                  v1, v2, v3;       // start pipeline occupancy
  logic                  s1_valid;         // table read stage holds a sample
  logic                  out_adv;
  logic                  s1_adv;
  logic                  fire;
  logic                  tick_emit;

  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_step;
  logic [COUNT_BITS-1:0] samples_left;

  assign out_adv   = !tone_valid || tone_ready;
  assign s1_adv    = !s1_valid || out_adv;
  // no item while a start is still working out the step and count
  assign req_ready = !(v1 || v2 || v3) && s1_adv;
  assign fire      = req_valid && req_ready;
  assign tick_emit = fire && (req.cmd == CMD_TICK) && (samples_left != '0);

  // ---------------------------------------------------------------------------
  // start pipeline
  // ---------------------------------------------------------------------------

  // stage 1: saturated frequency and duration
  logic [FREQ_W-1:0]     freq_r;
  logic [DUR_W-1:0]      dur_r;
  logic [FREQ_W-1:0]     freq_sat;

  assign freq_sat = (32'(req.frequency_hz) > 32'(FSAT)) ? FREQ_W'(FSAT) : req.frequency_hz;

  // stage 2: partial products
  logic [PHASE_BITS-1:0] step_hi2;
  logic [LO_W-1:0]       lo2;
  logic [CNT_W-1:0]      cnt_hi2;
  logic [CM_W-1:0]       cm2;

  // stage 3: quotients from the reciprocal products
  logic [PHASE_BITS-1:0] step_hi3;
  logic [QW-1:0]         q_lo3;
  logic [CNT_W-1:0]      cnt_hi3;
  logic [DUR_W-1:0]      q_cm3;

  logic [LO_PW-1:0]      lo_prod;
  logic [CM_PW-1:0]      cm_prod;
  logic [PHASE_BITS-1:0] step_next;
  logic [CNT_W-1:0]      cnt_sum;
  logic [COUNT_BITS-1:0] count_next;

  assign lo_prod    = LO_PW'(lo2) * LO_PW'(LO_M);
  assign cm_prod    = CM_PW'(cm2) * CM_PW'(CM_M);
  assign step_next  = step_hi3 + PHASE_BITS'(q_lo3);
  assign cnt_sum    = cnt_hi3 + CNT_W'(q_cm3);
  // long beeps saturate the counter
  assign count_next = (cnt_sum > CNT_W'(COUNT_MAX)) ? COUNT_MAX : cnt_sum[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= fire && (req.cmd == CMD_START);
      v2 <= v1;
      v3 <= v2;
    end
  end

  // payload of the start pipeline, no reset needed
  always_ff @(posedge clk) begin
    freq_r   <= freq_sat;
    dur_r    <= req.length_ms;
    step_hi2 <= PHASE_BITS'(PHASE_BITS'(freq_r) * PHASE_BITS'(STEP_Q));
    lo2      <= LO_W'(LO_W'(freq_r) * LO_W'(STEP_R) + LO_W'(RND));
    cnt_hi2  <= CNT_W'(CNT_W'(dur_r) * CNT_W'(CNT_D));
    cm2      <= CM_W'(CM_W'(dur_r) * CM_W'(CNT_R));
    step_hi3 <= step_hi2;
    q_lo3    <= QW'(lo_prod >> LO_S);
    cnt_hi3  <= cnt_hi2;
    q_cm3    <= DUR_W'(cm_prod >> CM_S);
  end

  // ---------------------------------------------------------------------------
  // phase accumulator and sample counter
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      phase_step   <= '0;
      samples_left <= '0;
    end else begin
      if (fire && (req.cmd == CMD_START)) begin
        // a start restarts the phase at once; step and count follow later
        phase_acc <= '0;
      end else if (tick_emit) begin
        phase_acc    <= phase_acc + phase_step;
        samples_left <= samples_left - COUNT_BITS'(1);
      end
      if (v3) begin
        phase_step   <= step_next;
        samples_left <= count_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // table read stage
  // ---------------------------------------------------------------------------

  // top bits of the phase: quadrant, then table address
  logic [1:0]                quadrant;
  logic [SINE_ADDR_BITS-1:0] qaddr;
  logic [ADDR_W-1:0]         rom_addr;
  logic [TBL_W-1:0]          rom_data;
  logic                      s1_neg;
  logic                      s1_last;

  assign quadrant = phase_acc[PHASE_BITS-1 -: 2];
  assign qaddr    = phase_acc[PHASE_BITS-3 -: SINE_ADDR_BITS];
  // odd quadrants run the table backwards
  assign rom_addr = quadrant[0] ? (ADDR_W'(QSIZE) - {1'b0, qaddr}) : {1'b0, qaddr};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= tick_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && tick_emit) begin
      rom_data <= sine_rom[rom_addr];
      s1_neg   <= quadrant[1];
      s1_last  <= (samples_left == COUNT_BITS'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // sign, saturation and output register
  // ---------------------------------------------------------------------------

  logic signed [SAMPLE_W-1:0] sample_next;
  logic signed [SAMPLE_W:0]   neg_wide;

  assign neg_wide = -$signed({1'b0, rom_data});

  always_comb begin
    if (s1_neg) begin
      if (32'(rom_data) > 32'(SAMPLE_NEG_MAG)) begin
        sample_next = -SAMPLE_W'(SAMPLE_NEG_MAG);
      end else begin
        sample_next = SAMPLE_W'(neg_wide);
      end
    end else begin
      if (32'(rom_data) > 32'(SAMPLE_POS_MAX)) begin
        sample_next = SAMPLE_W'(SAMPLE_POS_MAX);
      end else begin
        sample_next = $signed(rom_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_valid <= 1'b0;
    end else if (out_adv) begin
      tone_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      tone.sample <= sample_next;
      tone.last   <= s1_last;
    end
  end

endmodule

// ===== dv/tb_sine_beep_tone_generator.sv =====
`timescale 1ns / 1ps

module tb_sine_beep_tone_generator;
  import sbtg_pkg::*;

  localparam int PHASE_W      = DEF_PHASE_BITS;
  localparam int ADDR_W       = DEF_SINE_ADDR_BITS;
  localparam int QUARTER      = 1 << ADDR_W;
  localparam int NYQUIST      = DEF_AUDIO_RATE / 2;
  localparam int FREQ_MAX     = (1 << FREQ_W) - 1;
  localparam int DUR_MAX      = (1 << DUR_W) - 1;
  localparam int RANDOM_ITEMS = 1650;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 300000;

  // tracks the tone generator state and holds the samples still owed by the block
  class beep_tracker;
    int quarter_wave[QUARTER+1];
    bit [PHASE_W-1:0] phase;
    bit [PHASE_W-1:0] step;
    bit [COUNT_BITS-1:0] samples_left;
    tone_t pending_samples[$];
    int mismatches;
    int starts_seen;
    int samples_checked;
    int idle_ticks;

    function new();
      for (int k = 0; k < QUARTER; k++) begin
        quarter_wave[k] = sine_entry(k);
      end
      quarter_wave[QUARTER] = DEF_AMPLITUDE;
      phase = '0;
      step = '0;
      samples_left = '0;
    endfunction

    // taylor series of sin in q30 at the k-th quarter-wave point, scaled to amplitude
    function int sine_entry(int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned n;
      longint acc;
      longint scaled;
      x = (HALF_PI_Q30 * 64'(k)) >> ADDR_W;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      n = 1;
      while (term != 0 && n < 40) begin
        term = (term * x2) / ((2 * n) * (2 * n + 1));
        if (n[0]) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
        n++;
      end
      if (acc < 0) begin
        acc = 0;
      end
      scaled = (acc * DEF_AMPLITUDE) >> 30;
      if (scaled > DEF_AMPLITUDE) begin
        scaled = DEF_AMPLITUDE;
      end
      return int'(scaled);
    endfunction

    // returns 1 when the item does something (a start, or a tick that gives a sample)
    function bit note_req(req_t r);
      longint unsigned f;
      longint unsigned count;
      bit [ADDR_W+1:0] index;
      int level;
      tone_t expected;
      if (r.cmd == CMD_START) begin
        f = 64'(r.frequency_hz);
        if (f > NYQUIST) begin
          f = NYQUIST;
        end
        phase = '0;
        step = PHASE_W'(((f << PHASE_W) + NYQUIST) / DEF_AUDIO_RATE);
        count = 64'(r.length_ms) * DEF_AUDIO_RATE / MS_PER_S;
        if (count > COUNT_MAX) begin
          count = COUNT_MAX;
        end
        samples_left = COUNT_BITS'(count);
        starts_seen++;
        return 1'b1;
      end
      if (samples_left == 0) begin
        idle_ticks++;
        return 1'b0;
      end
      index = phase[PHASE_W-1 -: ADDR_W+2];
      if (index[ADDR_W]) begin
        level = quarter_wave[QUARTER - index[ADDR_W-1:0]];
      end else begin
        level = quarter_wave[index[ADDR_W-1:0]];
      end
      if (index[ADDR_W+1]) begin
        level = -level;
      end
      if (level > SAMPLE_POS_MAX) begin
        level = SAMPLE_POS_MAX;
      end
      if (level < -SAMPLE_NEG_MAG) begin
        level = -SAMPLE_NEG_MAG;
      end
      expected.sample = SAMPLE_W'(level);
      expected.last = (samples_left == 1);
      pending_samples.push_back(expected);
      phase = phase + step;
      samples_left = samples_left - 1'b1;
      return 1'b1;
    endfunction

    task flag_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_tone(tone_t got);
      tone_t want;
      if (pending_samples.size() == 0) begin
        flag_mismatch($sformatf("sample %0d last %0b with none expected",
                                got.sample, got.last));
        return;
      end
      want = pending_samples.pop_front();
      samples_checked++;
      if (got.sample !== want.sample) begin
        flag_mismatch($sformatf("sample %0d, expected %0d", got.sample, want.sample));
      end
      if (got.last !== want.last) begin
        flag_mismatch($sformatf("last %0b, expected %0b (sample %0d)",
                                got.last, want.last, want.sample));
      end
    endtask
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  tone_valid;
  logic  tone_ready = 1'b0;
  tone_t tone;

  beep_tracker tracker;
  int  cycles = 0;
  int  burst_left = 0;
  int  useful_items = 0;
  bit  hold_wanted = 1'b0;
  logic hold_off = 1'b0;

  sine_beep_tone_generator dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .tone_valid (tone_valid),
    .tone_ready (tone_ready),
    .tone       (tone)
  );

  always #5 clk = ~clk;

  // run limit, generous against the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_sine_beep_tone_generator NOT OK");
      $finish;
    end
  end

  // tone side: check every accepted sample, then pick the next ready level
  // the stall pattern changes with cycles[9:8]: always ready, coin flip,
  // one cycle in four, mostly ready
  always @(posedge clk) begin
    if (!rst && tone_valid && tone_ready) begin
      tracker.check_tone(tone);
    end
    if (hold_off) begin
      tone_ready <= 1'b0;
    end else begin
      case (cycles[9:8])
        2'd0: tone_ready <= 1'b1;
        2'd1: tone_ready <= 1'($urandom_range(0, 1));
        2'd2: tone_ready <= (cycles[1:0] == 2'd0);
        default: tone_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // one long hold-off of the tone side while ticks keep coming, so the block backs up
  initial begin
    wait (hold_wanted);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic req_t make_req(cmd_t c, int f, int d);
    req_t r;
    r.cmd = c;
    r.frequency_hz = FREQ_W'(f);
    r.length_ms = DUR_W'(d);
    return r;
  endfunction

  // offers one item and waits for it to be taken; the sender runs in bursts
  // with random gaps, and some bursts are long enough to give gap-free stretches
  task automatic offer(req_t r);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24);
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (tracker.note_req(r)) begin
      useful_items++;
    end
  endtask

  task automatic start_beep(int f, int d);
    offer(make_req(CMD_START, f, d));
  endtask

  // ticks carry junk in the unused fields, the block must ignore it
  task automatic send_ticks(int n);
    repeat (n) offer(make_req(CMD_TICK, $urandom_range(0, FREQ_MAX), $urandom_range(0, DUR_MAX)));
  endtask

  initial begin
    int roll;
    int freq;
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_ticks(1);                   // tick while idle
    start_beep(0, 0);                // zero length, stays idle
    send_ticks(1);
    start_beep(FREQ_MAX, DUR_MAX);   // above nyquist, longest beep
    send_ticks(3);
    start_beep(NYQUIST + 1, 1);      // just above nyquist
    send_ticks(2);
    // restart mid-beep; a quarter-turn step lands on both table ends
    start_beep(NYQUIST / 2, DUR_MAX);
    hold_wanted = 1'b1;
    send_ticks(10);
    start_beep(1, 1);                // lowest nonzero tone
    send_ticks(2);

    // random part: mostly complete beeps, some cut short, some long beeps
    // restarted early, and a few stray ticks
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 9);
      if ($urandom_range(0, 7) == 0) begin
        freq = $urandom_range(NYQUIST + 1, FREQ_MAX);
      end else begin
        freq = $urandom_range(0, NYQUIST);
      end
      if (roll < 2) begin
        start_beep(freq, $urandom_range(0, DUR_MAX));
        send_ticks($urandom_range(0, 80));
      end else if (roll == 2) begin
        send_ticks($urandom_range(1, 4));
      end else begin
        start_beep(freq, $urandom_range(0, 2));
        if (roll == 3) begin
          send_ticks($urandom_range(0, tracker.samples_left));
        end else begin
          send_ticks(tracker.samples_left + $urandom_range(0, 2));
        end
      end
    end

    // drain, then leave time for any stray sample
    req_valid <= 1'b0;
    while (tracker.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d beep starts, %0d samples compared, %0d ticks while idle",
             tracker.starts_seen, tracker.samples_checked, tracker.idle_ticks);
    $display("tone side held off once for %0d cycles with ticks pending", LONG_HOLD);
    if (tracker.mismatches == 0) begin
      $display("tb_sine_beep_tone_generator OK");
    end else begin
      $display("tb_sine_beep_tone_generator NOT OK");
    end
    $finish;
  end

endmodule
